[sv/bms2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear mass splat package
// Shared widths, codes, request and response payloads, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bms2d_pkg;

   // Default sizes of the grid and the accumulators.
   localparam int DEF_MAX_ROWS  = 256;
   localparam int DEF_MAX_COLS  = 256;
   localparam int DEF_ACC_WIDTH = 48;

   // Field widths of the request and response payloads.
   localparam int ACT_W  = 2;
   localparam int POS_W  = 32;
   localparam int MASS_W = 32;
   localparam int IDX_W  = 16;
   localparam int DATA_W = 48;

   // Fixed-point layout: Q16.16 positions, Q1.16 weights up to one.
   localparam int FRAC_W = 16;
   localparam int IP_W   = POS_W - FRAC_W - 1;
   localparam int W_W    = FRAC_W + 1;
   localparam int WP_W   = 2 * FRAC_W + 1;
   localparam logic [W_W-1:0] ONE_Q16 = W_W'(1) << FRAC_W;

   // Configuration port.
   localparam int CSR_W      = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int SIZE_RESET = 256;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   // Request actions.
   localparam logic [ACT_W-1:0] ACT_DEPOSIT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NOP     = 2'd3;

   // The four corners are visited in order; bit 0 steps the row, bit 1 the column.
   localparam logic [1:0] CORNER_LAST = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [POS_W-1:0] pos_row;
      logic signed [POS_W-1:0] pos_col;
      logic [MASS_W-1:0]       particle_mass;
      logic [IDX_W-1:0]        cell_index;
      logic [DATA_W-1:0]       cell_data;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  read_index;
      logic [DATA_W-1:0] read_value;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       base;
      logic       issue;
      logic [1:0] corner;
      logic       rd_issue;
      logic       wr_cell;
      logic       load_rsp;
      logic       clear_step;
   } bms2d_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             clear_last;
      logic             rsp_free;
   } bms2d_status_type;

endpackage

[sv/bms2d_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one deposit, read or write request.
// ----------------------------------------------------------------------------
interface bms2d_req_if;
   import bms2d_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        action;
   logic signed [POS_W-1:0] pos_row;
   logic signed [POS_W-1:0] pos_col;
   logic [MASS_W-1:0]       particle_mass;
   logic [IDX_W-1:0]        cell_index;
   logic [DATA_W-1:0]       cell_data;

   modport source (
      output valid, action, pos_row, pos_col, particle_mass, cell_index, cell_data,
      input  ready
   );

   modport sink (
      input  valid, action, pos_row, pos_col, particle_mass, cell_index, cell_data,
      output ready
   );
endinterface

[sv/bms2d_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that returns the index and content of a cell read.
// ----------------------------------------------------------------------------
interface bms2d_rsp_if;
   import bms2d_pkg::*;

   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  read_index;
   logic [DATA_W-1:0] read_value;

   modport source (
      output valid, read_index, read_value,
      input  ready
   );

   modport sink (
      input  valid, read_index, read_value,
      output ready
   );
endinterface

[sv/bms2d_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear mass splat controller
// State machine that clears the grid after reset, takes one request at a
// time and steps the datapath through decode, corner updates and responses.
// ----------------------------------------------------------------------------
module bms2d_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bms2d_pkg::bms2d_status_type status,
   output bms2d_pkg::bms2d_cmd_type    cmd
);
   import bms2d_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_BASE   = 3'd3;
   localparam logic [2:0] S_CORNER = 3'd4;
   localparam logic [2:0] S_READ   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;
   localparam logic [2:0] S_WRITE  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [1:0] corner_ff;
   logic [1:0] corner_in;

   // A new request is taken only between requests.
   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      corner_in = corner_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (status.action)
               ACT_DEPOSIT: state_in = S_BASE;
               ACT_READ:    state_in = S_READ;
               ACT_WRITE:   state_in = S_WRITE;
               default:     state_in = S_IDLE;
            endcase
         end
         S_BASE: begin
            cmd.base  = 1'b1;
            corner_in = '0;
            state_in  = S_CORNER;
         end
         S_CORNER: begin
            cmd.issue  = 1'b1;
            cmd.corner = corner_ff;
            corner_in  = corner_ff + 2'd1;
            if (corner_ff == CORNER_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            // Hold the read data until the output register can take it.
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WRITE: begin
            cmd.wr_cell = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

endmodule

[sv/bms2d_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear mass splat datapath
// Holds the grid size registers, the grid memory, the axis and address
// logic, the three-stage corner update pipeline and the response register.
// ----------------------------------------------------------------------------
module bms2d_dpath #(
   parameter int MAX_ROWS  = bms2d_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = bms2d_pkg::DEF_MAX_COLS,
   parameter int ACC_WIDTH = bms2d_pkg::DEF_ACC_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bms2d_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [bms2d_pkg::CSR_W-1:0]           csr_wdata,
   input  bms2d_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bms2d_pkg::rsp_type                    rsp_data,
   input  bms2d_pkg::bms2d_cmd_type              cmd,
   output bms2d_pkg::bms2d_status_type           status
);
   import bms2d_pkg::*;

   localparam int R_SZ_W = $clog2(MAX_ROWS + 1);
   localparam int C_SZ_W = $clog2(MAX_COLS + 1);
   localparam int R_W    = $clog2(MAX_ROWS);
   localparam int C_W    = $clog2(MAX_COLS);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = R_SZ_W + C_SZ_W;
   localparam int CMP_W  = (TOT_W > IDX_W) ? TOT_W : IDX_W;
   localparam int SZ_MAX = (R_SZ_W > C_SZ_W) ? R_SZ_W : C_SZ_W;
   localparam int AX_W   = (SZ_MAX > IP_W) ? SZ_MAX : IP_W;
   localparam int ROWS_RESET = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;
   localparam int COLS_RESET = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;

   typedef struct packed {
      logic [AX_W-1:0] slot;
      logic [W_W-1:0]  w;
   } axis_type;

   // Cell and weight along one axis; last is the highest cell on that axis.
   function automatic axis_type axis_calc(input logic [POS_W-1:0] pos,
                                          input logic [AX_W-1:0]  last);
      axis_type        a;
      logic [AX_W-1:0] ip;
      ip = AX_W'(pos[POS_W-2:FRAC_W]);
      if (pos[POS_W-1]) begin
         a.slot = '0;
         a.w    = ONE_Q16;
      end else if (ip >= last) begin
         a.slot = last;
         a.w    = ONE_Q16;
      end else begin
         a.slot = ip;
         a.w    = ONE_Q16 - {1'b0, pos[FRAC_W-1:0]};
      end
      return a;
   endfunction

   // Grid size registers, kept as effective sizes.
   logic [R_SZ_W-1:0] rows_ff;
   logic [C_SZ_W-1:0] cols_ff;
   logic [R_SZ_W-1:0] rows_in;
   logic [C_SZ_W-1:0] cols_in;

   // Captured request.
   logic [ACT_W-1:0]  act_ff;
   logic [POS_W-1:0]  pos_row_ff;
   logic [POS_W-1:0]  pos_col_ff;
   logic [MASS_W-1:0] mass_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] cdata_ff;

   // Decode results.
   logic [R_W-1:0]    rcell_ff;
   logic [C_W-1:0]    ccell_ff;
   logic [W_W-1:0]    wr_ff;
   logic [W_W-1:0]    wc_ff;
   logic              rn_ff;
   logic              cn_ff;
   logic              in_range_ff;
   logic [ADDR_W-1:0] base_ff;

   // Corner pipeline.
   logic              p1_go_ff;
   logic [ADDR_W-1:0] p1_addr_ff;
   logic [WP_W-1:0]   p1_wprod_ff;
   logic              p2_go_ff;
   logic [ADDR_W-1:0] p2_addr_ff;
   logic [MASS_W-1:0] p2_amt_ff;

   // Memory and clearing pass.
   logic [ACC_WIDTH-1:0] grid_mem [DEPTH];
   logic [ACC_WIDTH-1:0] rdata_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;

   // Response register.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;

   // Combinational helpers.
   logic [AX_W-1:0]       rows_last;
   logic [AX_W-1:0]       cols_last;
   axis_type              ra;
   axis_type              ca;
   logic [TOT_W-1:0]      total;
   logic [ADDR_W-1:0]     idx_addr;
   logic                  dr;
   logic                  dc;
   logic [W_W-1:0]        wsel_r;
   logic [W_W-1:0]        wsel_c;
   logic                  corner_en;
   logic [ADDR_W-1:0]     corner_addr;
   logic [2*W_W-1:0]      wprod_full;
   logic [2*MASS_W-1:0]   mprod;
   logic [MASS_W-1:0]     amt_in;
   logic [ACC_WIDTH:0]    sum;
   logic [ACC_WIDTH-1:0]  sat_sum;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [ACC_WIDTH-1:0]  mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;

   // Clamp register writes to the supported grid.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we && csr_idx == CSR_GRID_ROWS) begin
         if (csr_wdata == '0) begin
            rows_in = R_SZ_W'(1);
         end else if (32'(csr_wdata) > 32'(MAX_ROWS)) begin
            rows_in = R_SZ_W'(MAX_ROWS);
         end else begin
            rows_in = R_SZ_W'(csr_wdata);
         end
      end
      if (csr_we && csr_idx == CSR_GRID_COLS) begin
         if (csr_wdata == '0) begin
            cols_in = C_SZ_W'(1);
         end else if (32'(csr_wdata) > 32'(MAX_COLS)) begin
            cols_in = C_SZ_W'(MAX_COLS);
         end else begin
            cols_in = C_SZ_W'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= R_SZ_W'(ROWS_RESET);
         cols_ff <= C_SZ_W'(COLS_RESET);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_data.action;
         pos_row_ff <= req_data.pos_row;
         pos_col_ff <= req_data.pos_col;
         mass_ff    <= req_data.particle_mass;
         idx_ff     <= req_data.cell_index;
         cdata_ff   <= req_data.cell_data;
      end
   end

   // Decode: cell and weight on each axis, and the index range check.
   assign rows_last = AX_W'(rows_ff - R_SZ_W'(1));
   assign cols_last = AX_W'(cols_ff - C_SZ_W'(1));
   assign ra        = axis_calc(pos_row_ff, rows_last);
   assign ca        = axis_calc(pos_col_ff, cols_last);
   assign total     = TOT_W'(rows_ff) * TOT_W'(cols_ff);
   assign idx_addr  = ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         rcell_ff    <= R_W'(ra.slot);
         ccell_ff    <= C_W'(ca.slot);
         wr_ff       <= ra.w;
         wc_ff       <= ca.w;
         rn_ff       <= (ra.slot != rows_last);
         cn_ff       <= (ca.slot != cols_last);
         in_range_ff <= (CMP_W'(idx_ff) < CMP_W'(total));
      end
      if (cmd.base) begin
         base_ff <= ADDR_W'(rcell_ff) * ADDR_W'(cols_ff) + ADDR_W'(ccell_ff);
      end
   end

   // Corner issue: select the axis weights, the address and whether it is on the grid.
   assign dr     = cmd.corner[0];
   assign dc     = cmd.corner[1];
   assign wsel_r = dr ? (ONE_Q16 - wr_ff) : wr_ff;
   assign wsel_c = dc ? (ONE_Q16 - wc_ff) : wc_ff;

   always_comb begin
      corner_addr = base_ff;
      if (dr) begin
         corner_addr = corner_addr + ADDR_W'(cols_ff);
      end
      if (dc) begin
         corner_addr = corner_addr + ADDR_W'(1);
      end
      case ({dc, dr})
         2'b00:   corner_en = 1'b1;
         2'b01:   corner_en = rn_ff;
         2'b10:   corner_en = cn_ff;
         2'b11:   corner_en = rn_ff && cn_ff;
         default: corner_en = 1'b0;
      endcase
   end

   // Stage one: weight product. Stage two: share of the mass, floored to Q16.16.
   assign wprod_full = {{W_W{1'b0}}, wsel_r} * {{W_W{1'b0}}, wsel_c};
   assign mprod      = {{MASS_W{1'b0}}, p1_wprod_ff[2*FRAC_W-1:0]} *
                       {{MASS_W{1'b0}}, mass_ff};
   // A full weight of one passes the mass through unchanged.
   assign amt_in     = p1_wprod_ff[WP_W-1] ? mass_ff : mprod[2*MASS_W-1:MASS_W];

   always_ff @(posedge clock) begin
      p1_addr_ff  <= corner_addr;
      p1_wprod_ff <= wprod_full[WP_W-1:0];
      p2_addr_ff  <= p1_addr_ff;
      p2_amt_ff   <= amt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_go_ff <= 1'b0;
         p2_go_ff <= 1'b0;
      end else begin
         p1_go_ff <= cmd.issue && corner_en;
         p2_go_ff <= p1_go_ff;
      end
   end

   // Stage three: saturating accumulate into the cell read in stage two.
   assign sum     = {1'b0, rdata_ff} + (ACC_WIDTH + 1)'(p2_amt_ff);
   assign sat_sum = sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum[ACC_WIDTH-1:0];

   // Memory port selection.
   always_comb begin
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.wr_cell) begin
         mem_we    = in_range_ff;
         mem_waddr = idx_addr;
         mem_wdata = ACC_WIDTH'(cdata_ff);
      end else begin
         mem_we    = p2_go_ff;
         mem_waddr = p2_addr_ff;
         mem_wdata = sat_sum;
      end
      mem_re    = cmd.rd_issue || p1_go_ff;
      mem_raddr = cmd.rd_issue ? idx_addr : p1_addr_ff;
   end

   // Grid memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= grid_mem[mem_raddr];
      end
   end

   // Clearing pass address after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   // Response register; a read outside the grid returns zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.read_index <= idx_ff;
         rsp_data_ff.read_value <= in_range_ff ? DATA_W'(rdata_ff) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.action     = act_ff;
   assign status.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // The clearing pass owns the write port alone.
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !p2_go_ff && !cmd.wr_cell)
      else $error("clearing pass shares the write port");

   // Back-to-back corners never read the cell that is being written.
   a_corner_distinct: assert property (@(posedge clock) disable iff (reset)
      (p1_go_ff && p2_go_ff) |-> (p1_addr_ff != p2_addr_ff))
      else $error("corner read and write hit the same cell");

   // A corner update stays inside the configured grid.
   a_corner_in_grid: assert property (@(posedge clock) disable iff (reset)
      p2_go_ff |-> (CMP_W'(p2_addr_ff) < CMP_W'(total)))
      else $error("corner update outside the grid");

   // A cell read never competes with a corner read.
   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |-> !p1_go_ff)
      else $error("cell read collides with a corner read");

endmodule

[sv/bilinear_mass_splat_2d_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear mass splat, 2D
// Cloud-in-cell deposit of particle mass onto a row-major grid, with single
// cell read and write requests.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid / ready      action, pos_row, pos_col,
//                                           particle_mass, cell_index, cell_data
//   rsp_chan  out        valid / ready      read_index, read_value
//   csr_*     in         csr_we             csr_idx, csr_wdata
//
// A deposit runs decode, base address, then the four corners in turn through
// the read-modify-write pipeline on the grid memory. A read runs decode, read
// and response; a write runs decode and write; an unused action only decode.
// After reset a clearing pass zeroes all MAX_ROWS * MAX_COLS cells of the grid,
// one cell per cycle, with req_chan.ready low.
// A read request waits in its last cycle while the output register still holds
// an untaken response; the next request is accepted while a response waits.
// ----------------------------------------------------------------------------
module bilinear_mass_splat_2d_unit #(
   parameter int MAX_ROWS  = bms2d_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = bms2d_pkg::DEF_MAX_COLS,
   parameter int ACC_WIDTH = bms2d_pkg::DEF_ACC_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   bms2d_req_if.sink                       req_chan,
   bms2d_rsp_if.source                     rsp_chan,
   input  logic                            csr_we,
   input  logic [bms2d_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [bms2d_pkg::CSR_W-1:0]     csr_wdata
);
   import bms2d_pkg::*;

   bms2d_cmd_type    cmd;
   bms2d_status_type status;
   req_type          req_data;
   rsp_type          rsp_data;
   logic             req_ready;
   logic             rsp_valid;

   // Request payload bundle.
   assign req_data.action        = req_chan.action;
   assign req_data.pos_row       = req_chan.pos_row;
   assign req_data.pos_col       = req_chan.pos_col;
   assign req_data.particle_mass = req_chan.particle_mass;
   assign req_data.cell_index    = req_chan.cell_index;
   assign req_data.cell_data     = req_chan.cell_data;
   assign req_chan.ready         = req_ready;

   // Response channel.
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.read_index = rsp_data.read_index;
   assign rsp_chan.read_value = rsp_data.read_value;

   bms2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bms2d_dpath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[tb/sv/bilinear_mass_splat_2d_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear mass splat testbench
// Sends deposit, read, write and no-op requests through the request channel
// and keeps a shadow copy of the grid, updated as each request is accepted.
// Every read response is compared field by field with the predicted cell.
// The grid shape is reprogrammed between phases, including clamped sizes,
// and in most phases both channels stall at random.
// ----------------------------------------------------------------------------
module bilinear_mass_splat_2d_unit_tb;
   import bms2d_pkg::*;

   localparam int GRID_ROWS_MAX = DEF_MAX_ROWS;
   localparam int GRID_COLS_MAX = DEF_MAX_COLS;
   localparam int GRID_CELLS    = GRID_ROWS_MAX * GRID_COLS_MAX;
   localparam logic [DATA_W-1:0] ACC_FULL = '1;

   // Long enough to cover any request still in progress.
   localparam int SETTLE_CYCLES = 16;
   // Clearing pass plus about a thousand slow requests, taken several times over.
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASE_ITEMS   = 115;

   // Stall percentages of the sender and the receiver.
   localparam int IDLE_LIGHT = 20;
   localparam int IDLE_HEAVY = 52;
   localparam int IDLE_NONE  = 0;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_W-1:0]     csr_wdata;

   bms2d_req_if req_if ();
   bms2d_rsp_if rsp_if ();

   bilinear_mass_splat_2d_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // Shadow grid and shadow registers.
   logic [DATA_W-1:0] grid_img [GRID_CELLS];
   logic [CSR_W-1:0]  rows_reg;
   logic [CSR_W-1:0]  cols_reg;

   req_type     request_q [$];
   rsp_type     pending_reads [$];
   req_type     in_flight;
   int          send_idle_pct;
   int          recv_idle_pct;
   int unsigned near_cell;
   int unsigned queued_count;
   int unsigned accepted_count;
   int unsigned deposit_count;
   int unsigned read_count;
   int unsigned write_count;
   int unsigned checked_count;
   int unsigned error_count;
   int unsigned shape_count;
   longint unsigned cycle_count = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d reads still pending.",
                  cycle_count, pending_reads.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int unsigned eff_size(logic [CSR_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // Cell and weight along one axis of n points for a Q16.16 position.
   function automatic void axis_locate(input logic [POS_W-1:0] raw, input int unsigned n,
                                       output int unsigned slot, output logic [W_W-1:0] wt);
      int unsigned ip;
      int unsigned last;
      last = n - 1;
      ip   = 32'(raw[POS_W-2:FRAC_W]);
      if (raw[POS_W-1]) begin
         slot = 0;
         wt   = ONE_Q16;
      end else if (ip >= last) begin
         slot = last;
         wt   = (64'(raw) <= (64'(last) << FRAC_W)) ?
                ONE_Q16 - {1'b0, raw[FRAC_W-1:0]} : ONE_Q16;
      end else begin
         slot = ip;
         wt   = ONE_Q16 - {1'b0, raw[FRAC_W-1:0]};
      end
   endfunction

   // Share of one corner: product of both weights and the mass, floored.
   function automatic logic [63:0] corner_share(logic [W_W-1:0] wa, logic [W_W-1:0] wb,
                                                logic [MASS_W-1:0] m);
      return (64'(wa) * 64'(wb) * 64'(m)) >> 32;
   endfunction

   function automatic void add_saturating(int unsigned idx, logic [63:0] amt);
      logic [63:0] sum;
      sum = 64'(grid_img[idx]) + amt;
      grid_img[idx] = (sum > 64'(ACC_FULL)) ? ACC_FULL : sum[DATA_W-1:0];
   endfunction

   // Applies one accepted request to the shadow grid; a read queues its response.
   function automatic void apply_request(req_type rq);
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      total;
      int unsigned      r;
      int unsigned      c;
      logic [W_W-1:0]   wr;
      logic [W_W-1:0]   wc;
      logic [W_W-1:0]   wr1;
      logic [W_W-1:0]   wc1;
      rsp_type          rs;
      rows  = eff_size(rows_reg, GRID_ROWS_MAX);
      cols  = eff_size(cols_reg, GRID_COLS_MAX);
      total = rows * cols;
      case (rq.action)
         ACT_DEPOSIT: begin
            axis_locate(rq.pos_row, rows, r, wr);
            axis_locate(rq.pos_col, cols, c, wc);
            wr1 = ONE_Q16 - wr;
            wc1 = ONE_Q16 - wc;
            add_saturating(r * cols + c, corner_share(wr, wc, rq.particle_mass));
            if (r + 1 < rows)
               add_saturating((r + 1) * cols + c, corner_share(wr1, wc, rq.particle_mass));
            if (c + 1 < cols)
               add_saturating(r * cols + c + 1, corner_share(wr, wc1, rq.particle_mass));
            if (r + 1 < rows && c + 1 < cols)
               add_saturating((r + 1) * cols + c + 1,
                              corner_share(wr1, wc1, rq.particle_mass));
            deposit_count++;
         end
         ACT_READ: begin
            rs.read_index = rq.cell_index;
            rs.read_value = (rq.cell_index < total) ? grid_img[rq.cell_index] : '0;
            pending_reads.push_back(rs);
            read_count++;
         end
         ACT_WRITE: begin
            if (rq.cell_index < total) grid_img[rq.cell_index] = rq.cell_data;
            write_count++;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_type build_req(logic [ACT_W-1:0] act, logic [POS_W-1:0] pr,
                                         logic [POS_W-1:0] pc, logic [MASS_W-1:0] m,
                                         logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      req_type rq;
      rq.action        = act;
      rq.pos_row       = pr;
      rq.pos_col       = pc;
      rq.particle_mass = m;
      rq.cell_index    = idx;
      rq.cell_data     = data;
      return rq;
   endfunction

   // Position mostly inside the grid, sometimes just outside, sometimes anywhere.
   function automatic logic [POS_W-1:0] rand_pos(int unsigned n);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return $urandom;
      if (pick == 1) return POS_W'($urandom_range(n - 1)) << FRAC_W;
      if (pick == 2) return POS_W'($urandom_range((n + 1) << FRAC_W)) - POS_W'(1 << FRAC_W);
      return (POS_W'($urandom_range(n - 1)) << FRAC_W) | POS_W'($urandom_range(16'hFFFF));
   endfunction

   // Cell index: mostly around the last deposit, sometimes past the grid end.
   function automatic logic [IDX_W-1:0] rand_index(int unsigned total, int unsigned cols);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick <= 4) begin
         case ($urandom_range(3))
            0: return IDX_W'(near_cell);
            1: return IDX_W'(near_cell + 1);
            2: return IDX_W'(near_cell + cols);
            default: return IDX_W'(near_cell + cols + 1);
         endcase
      end
      if (pick <= 7) return IDX_W'($urandom_range(total - 1));
      if (pick == 8 && total < GRID_CELLS) return IDX_W'($urandom_range(GRID_CELLS - 1, total));
      return IDX_W'($urandom);
   endfunction

   function automatic req_type make_request();
      req_type        rq;
      int unsigned    rows;
      int unsigned    cols;
      int unsigned    pick;
      int unsigned    r;
      int unsigned    c;
      logic [W_W-1:0] w;
      rows = eff_size(rows_reg, GRID_ROWS_MAX);
      cols = eff_size(cols_reg, GRID_COLS_MAX);
      rq = build_req(ACT_NOP, $urandom, $urandom, $urandom, IDX_W'($urandom),
                     DATA_W'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 45) begin
         rq.action  = ACT_DEPOSIT;
         rq.pos_row = rand_pos(rows);
         rq.pos_col = rand_pos(cols);
         case ($urandom_range(9))
            0: rq.particle_mass = '1;
            1: rq.particle_mass = '0;
            2: rq.particle_mass = $urandom_range(16'hFFFF);
            default: rq.particle_mass = $urandom;
         endcase
         axis_locate(rq.pos_row, rows, r, w);
         axis_locate(rq.pos_col, cols, c, w);
         near_cell = r * cols + c;
      end else if (pick < 80) begin
         rq.action     = ACT_READ;
         rq.cell_index = rand_index(rows * cols, cols);
      end else if (pick < 94) begin
         rq.action     = ACT_WRITE;
         rq.cell_index = rand_index(rows * cols, cols);
         pick = $urandom_range(9);
         // Values close to full let later deposits hit saturation.
         if (pick >= 7) rq.cell_data = DATA_W'($urandom_range(1 << 20));
         else if (pick >= 4) rq.cell_data = ACC_FULL - DATA_W'($urandom_range(1 << 20));
      end
      return rq;
   endfunction

   task automatic queue_request(req_type rq);
      request_q.push_back(rq);
      queued_count++;
   endtask

   // Waits until every request is taken and every read answered, then lets
   // any deposit or write still in progress finish.
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || pending_reads.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_GRID_ROWS) rows_reg = value;
      else cols_reg = value;
   endtask

   // One phase of random requests on a new grid shape; optionally the sender
   // holds off halfway until the block has drained.
   task automatic run_phase(logic [CSR_W-1:0] rows, logic [CSR_W-1:0] cols,
                            int send_pct, int recv_pct, bit hold_midway);
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_GRID_COLS, cols);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      shape_count++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (hold_midway && i == PHASE_ITEMS / 2) wait_idle();
         queue_request(make_request());
      end
      wait_idle();
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Request driver: takes the next request from the queue when the channel is free.
   always @(posedge clock) begin : drive_proc
      req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            apply_request(in_flight);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = request_q.pop_front();
               in_flight = nxt;
               req_if.valid         <= 1'b1;
               req_if.action        <= nxt.action;
               req_if.pos_row       <= nxt.pos_row;
               req_if.pos_col       <= nxt.pos_col;
               req_if.particle_mass <= nxt.particle_mass;
               req_if.cell_index    <= nxt.cell_index;
               req_if.cell_data     <= nxt.cell_data;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each read response with the oldest prediction.
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_reads.size() == 0) begin
               report_mismatch($sformatf("response for cell %0d with no read pending",
                                         rsp_if.read_index));
            end else begin
               want = pending_reads.pop_front();
               checked_count++;
               if (rsp_if.read_index !== want.read_index)
                  report_mismatch($sformatf("read_index %0d, predicted %0d",
                                            rsp_if.read_index, want.read_index));
               if (rsp_if.read_value !== want.read_value)
                  report_mismatch($sformatf("cell %0d read_value %h, predicted %h",
                                            want.read_index, rsp_if.read_value,
                                            want.read_value));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Main sequence: reset, directed requests, then random phases.
   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_idx              = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.action        = ACT_NOP;
      req_if.pos_row       = '0;
      req_if.pos_col       = '0;
      req_if.particle_mass = '0;
      req_if.cell_index    = '0;
      req_if.cell_data     = '0;
      rsp_if.ready         = 1'b0;
      rows_reg             = SIZE_RESET;
      cols_reg             = SIZE_RESET;
      near_cell            = 0;
      queued_count         = 0;
      accepted_count       = 0;
      deposit_count        = 0;
      read_count           = 0;
      write_count          = 0;
      checked_count        = 0;
      error_count          = 0;
      shape_count          = 1;
      send_idle_pct        = IDLE_LIGHT;
      recv_idle_pct        = IDLE_HEAVY;
      for (int i = 0; i < GRID_CELLS; i++) grid_img[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed requests on the reset grid shape of 256 by 256.
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd0, '0));
      // Integer position: the whole mass lands on one cell.
      queue_request(build_req(ACT_DEPOSIT, '0, '0, 32'h0001_0000, '0, '0));
      // Fractional position spread over four cells.
      queue_request(build_req(ACT_DEPOSIT, 32'h0001_8000, 32'h0002_4000, 32'h0003_0000,
                              '0, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd258, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd259, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd514, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd515, '0));
      // Negative positions clamp to the first cell with full weight.
      queue_request(build_req(ACT_DEPOSIT, 32'hFFFC_8000, 32'hFFFF_C000, '1, '0, '0));
      // Positions past the far edge and exactly on it.
      queue_request(build_req(ACT_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '0, '0));
      queue_request(build_req(ACT_DEPOSIT, 32'h00FF_0000, 32'h00FF_0000, '1, '0, '0));
      queue_request(build_req(ACT_DEPOSIT, 32'h00FE_C000, '0, '1, '0, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'hFFFF, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd65024, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd65280, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd0, '0));
      // Nearly full cell, then a deposit that saturates it.
      queue_request(build_req(ACT_WRITE, '0, '0, '0, 16'd100, 48'hFFFF_FFFF_FFF0));
      queue_request(build_req(ACT_DEPOSIT, '0, 32'h0064_0000, '1, '0, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd100, '0));
      queue_request(build_req(ACT_WRITE, '0, '0, '0, 16'd0, '1));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd0, '0));
      // Most negative positions with zero mass change nothing.
      queue_request(build_req(ACT_DEPOSIT, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
      // The unused action has no effect, even with every field set.
      queue_request(build_req(ACT_NOP, '1, '1, '1, 16'd1, '1));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'd1, '0));
      queue_request(build_req(ACT_WRITE, '0, '0, '0, 16'hFFFF, '0));
      queue_request(build_req(ACT_READ, '0, '0, '0, 16'hFFFF, '0));
      wait_idle();

      // Random phases over several grid shapes and stall patterns.
      run_phase(9'd4,   9'd5,   IDLE_LIGHT, IDLE_HEAVY, 1'b0);
      run_phase(9'd1,   9'd7,   IDLE_LIGHT, IDLE_HEAVY, 1'b0);
      run_phase(9'd0,   9'd0,   IDLE_HEAVY, IDLE_LIGHT, 1'b0);
      run_phase(9'd511, 9'd3,   IDLE_HEAVY, IDLE_LIGHT, 1'b0);
      run_phase(9'd256, 9'd256, IDLE_HEAVY, IDLE_LIGHT, 1'b1);
      run_phase(9'd9,   9'd511, IDLE_NONE,  IDLE_NONE,  1'b0);
      run_phase(9'd2,   9'd2,   IDLE_NONE,  IDLE_NONE,  1'b0);
      run_phase(9'd17,  9'd33,  IDLE_NONE,  IDLE_NONE,  1'b0);

      $display("Ran %0d requests: %0d deposits, %0d reads, %0d writes, the rest no-ops.",
               accepted_count, deposit_count, read_count, write_count);
      $display("Compared %0d read responses over %0d grid shapes, clamped sizes included.",
               checked_count, shape_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
